>>> design/directed_graph_edge_store_assert.svh
// Assertion macros used by the edge store sequencer.
`ifndef DIRECTED_GRAPH_EDGE_STORE_ASSERT_SVH
`define DIRECTED_GRAPH_EDGE_STORE_ASSERT_SVH

// same-cycle implication
`define DGES_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DGES_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/dges_pkg.sv
// Types and constants of the directed graph edge store.
`default_nettype none

package dges_pkg;

	localparam int VID_W  = 7;
	localparam int OP_W   = 3;
	localparam int DEG_W  = 6;
	localparam int CNT_W  = 12;
	localparam int PROD_W = 2 * VID_W;

	// one memory word per vertex pair lo < hi
	localparam int WORD_W  = 2;
	localparam int FWD_BIT = 0;
	localparam int BWD_BIT = 1;

	typedef enum logic [OP_W-1:0] {
		OP_TEST   = 3'd0,
		OP_SET    = 3'd1,
		OP_ERASE  = 3'd2,
		OP_OUTDEG = 3'd3,
		OP_INDEG  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_WALK,
		ST_DRAIN,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic             status;
		logic             connected;
		logic             changed;
		logic [DEG_W-1:0] degree;
		logic [CNT_W-1:0] total_edges;
	} result_t;

endpackage

`default_nettype wire

>>> design/directed_graph_edge_store.sv
// Directed graph edge store top level: config register, output register, sequencer and memory.
// Edges over vertices 1..V live in one memory of MAX_VERTICES*(MAX_VERTICES-1)/2 two-bit
// words, one per vertex pair (lower-to-higher bit and higher-to-lower bit), with a registered
// read. Edge test, set and erase go through the accept cycle, the slot read and the write back,
// which also loads the result. Degree queries read one word per other vertex through the
// single read port. Rejected items finish in the accept cycle. A result waits in the block
// while out_stall is high and the next item is taken once it is parked. After reset a
// clearing pass writes every word (2016 at 64 vertices) with in_stall high; configuration
// writes are taken throughout.
`default_nettype none

module directed_graph_edge_store #(
	parameter int MAX_VERTICES = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output      logic                       in_stall,
	input  wire logic [dges_pkg::OP_W-1:0]  operation,
	input  wire logic [dges_pkg::VID_W-1:0] source_vertex,
	input  wire logic [dges_pkg::VID_W-1:0] target_vertex,
	input  wire logic                       cfg_valid,
	output      logic                       cfg_ready,
	input  wire logic [dges_pkg::VID_W-1:0] cfg_data,
	output      logic                       out_valid,
	input  wire logic                       out_stall,
	output      logic                       status,
	output      logic                       connected,
	output      logic                       changed,
	output      logic [dges_pkg::DEG_W-1:0] degree,
	output      logic [dges_pkg::CNT_W-1:0] total_edges
);
	import dges_pkg::*;

	localparam int EDGE_SLOTS = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
	localparam int SLOT_W     = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;

	logic [VID_W-1:0]  vertex_count_q;
	logic              out_valid_q;
	result_t           out_q, res;
	logic              out_free, load;
	logic              rd_en, wr_en;
	logic [SLOT_W-1:0] rd_addr, wr_addr;
	logic [WORD_W-1:0] rd_data, wr_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			vertex_count_q <= cfg_data;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign connected   = out_q.connected;
	assign changed     = out_q.changed;
	assign degree      = out_q.degree;
	assign total_edges = out_q.total_edges;

	dges_seq #(
		.MAX_VERTICES (MAX_VERTICES),
		.EDGE_SLOTS   (EDGE_SLOTS),
		.SLOT_W       (SLOT_W)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.source_vertex (source_vertex),
		.target_vertex (target_vertex),
		.vertex_count  (vertex_count_q),
		.out_free      (out_free),
		.load          (load),
		.res           (res),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data)
	);

	dges_ram #(
		.DEPTH  (EDGE_SLOTS),
		.ADDR_W (SLOT_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

`default_nettype wire

>>> design/dges_ram.sv
// Edge bit memory: one 2-bit word per vertex pair, one write and one read port.
`default_nettype none

module dges_ram #(
	parameter int DEPTH  = 2016,
	parameter int ADDR_W = 11
) (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [ADDR_W-1:0]           wr_addr,
	input  wire logic [dges_pkg::WORD_W-1:0] wr_data,
	input  wire logic                        rd_en,
	input  wire logic [ADDR_W-1:0]           rd_addr,
	output      logic [dges_pkg::WORD_W-1:0] rd_data
);
	import dges_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> design/dges_seq.sv
// Sequencer: clearing pass, edge read-modify-write and degree walk over the memory.
`default_nettype none

`include "directed_graph_edge_store_assert.svh"

module dges_seq #(
	parameter int MAX_VERTICES = 64,
	parameter int EDGE_SLOTS   = 2016,
	parameter int SLOT_W       = 11
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output      logic                        in_stall,
	input  wire logic [dges_pkg::OP_W-1:0]   operation,
	input  wire logic [dges_pkg::VID_W-1:0]  source_vertex,
	input  wire logic [dges_pkg::VID_W-1:0]  target_vertex,
	input  wire logic [dges_pkg::VID_W-1:0]  vertex_count,
	input  wire logic                        out_free,
	output      logic                        load,
	output      dges_pkg::result_t           res,
	output      logic                        rd_en,
	output      logic [SLOT_W-1:0]           rd_addr,
	input  wire logic [dges_pkg::WORD_W-1:0] rd_data,
	output      logic                        wr_en,
	output      logic [SLOT_W-1:0]           wr_addr,
	output      logic [dges_pkg::WORD_W-1:0] wr_data
);
	import dges_pkg::*;

	localparam logic [SLOT_W-1:0] M_SLOT   = SLOT_W'(MAX_VERTICES);
	localparam logic [SLOT_W-1:0] ONE_SLOT = SLOT_W'(1);
	localparam logic [SLOT_W-1:0] TWO_SLOT = SLOT_W'(2);

	state_t state_q, state_d;

	logic [OP_W-1:0]   op_q;
	logic [VID_W-1:0]  v_q, lo_q, hi_q, u_q;
	logic              fwd_q, inc_q;
	logic [PROD_W-1:0] prod_q;
	logic [SLOT_W-1:0] addr_q;
	logic [DEG_W-1:0]  cnt_q, cnt_d;
	logic [CNT_W-1:0]  count_q, count_d;
	result_t           res_q, res_d;
	logic              tag_valid_s1, tag_fw_s1;

	logic [VID_W-1:0]  nv, lo_d, hi_d, r_lo;
	logic              s_ok, t_ok, edge_ok, is_edge, is_deg;
	logic              accept, finish, hit, conn, chg;
	logic [SLOT_W-1:0] slot, step;
	logic [WORD_W-1:0] new_word;

	always_comb begin
		if (32'(vertex_count) > MAX_VERTICES) begin
			nv = VID_W'(MAX_VERTICES);
		end else begin
			nv = vertex_count;
		end
	end

	assign s_ok    = (source_vertex != '0) && (source_vertex <= nv);
	assign t_ok    = (target_vertex != '0) && (target_vertex <= nv);
	assign edge_ok = s_ok && t_ok && (source_vertex != target_vertex);
	assign is_edge = (operation == OP_TEST) || (operation == OP_SET) || (operation == OP_ERASE);
	assign is_deg  = (operation == OP_OUTDEG) || (operation == OP_INDEG);
	assign lo_d    = (source_vertex < target_vertex) ? source_vertex : target_vertex;
	assign hi_d    = (source_vertex < target_vertex) ? target_vertex : source_vertex;

	// slot = (lo-1)*M - (lo-1)*lo/2 + hi-lo-1, modulo 2^SLOT_W
	assign r_lo = lo_q - VID_W'(1);
	assign slot = (SLOT_W'(r_lo) * M_SLOT) - SLOT_W'(prod_q >> 1)
		+ SLOT_W'(hi_q - lo_q - VID_W'(1));

	// walk address step: column of the lower store, then row
	assign step = (u_q < v_q) ? (M_SLOT - SLOT_W'(u_q) - ONE_SLOT) : ONE_SLOT;

	assign hit   = tag_valid_s1 && (tag_fw_s1 ? rd_data[FWD_BIT] : rd_data[BWD_BIT]);
	assign cnt_d = cnt_q + DEG_W'(hit);

	assign conn = fwd_q ? rd_data[FWD_BIT] : rd_data[BWD_BIT];
	assign chg  = ((op_q == OP_SET) && !conn) || ((op_q == OP_ERASE) && conn);

	always_comb begin
		new_word = rd_data;
		if (op_q == OP_SET) begin
			if (fwd_q) new_word[FWD_BIT] = 1'b1;
			else       new_word[BWD_BIT] = 1'b1;
		end else if (op_q == OP_ERASE) begin
			if (fwd_q) new_word[FWD_BIT] = 1'b0;
			else       new_word[BWD_BIT] = 1'b0;
		end
	end

	always_comb begin
		count_d = count_q;
		if (chg && (op_q == OP_SET)) begin
			count_d = count_q + CNT_W'(1);
		end else if (chg) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		accept   = 1'b0;
		finish   = 1'b0;
		res_d    = '{status: 1'b1, connected: 1'b0, changed: 1'b0,
			degree: '0, total_edges: count_q};
		rd_en    = 1'b0;
		rd_addr  = addr_q;
		wr_en    = 1'b0;
		wr_addr  = addr_q;
		wr_data  = new_word;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_data = '0;
				if (32'(addr_q) == EDGE_SLOTS - 1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				accept   = in_valid;
				if (in_valid) begin
					if (is_edge && edge_ok) begin
						state_d = ST_READ;
					end else if (is_deg && s_ok) begin
						state_d = ST_WALK;
					end else begin
						finish = 1'b1;
					end
				end
			end
			ST_READ: begin
				rd_en   = 1'b1;
				rd_addr = slot;
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				wr_en  = 1'b1;
				finish = 1'b1;
				res_d  = '{status: 1'b0, connected: conn, changed: chg,
					degree: '0, total_edges: count_d};
			end
			ST_WALK: begin
				rd_en = (u_q != v_q);
				if (u_q == nv) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				finish = 1'b1;
				res_d  = '{status: 1'b0, connected: 1'b0, changed: 1'b0,
					degree: cnt_d, total_edges: count_q};
			end
			ST_HOLD: begin
				finish = 1'b1;
				res_d  = res_q;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
		if (finish) begin
			state_d = out_free ? ST_IDLE : ST_HOLD;
		end
	end

	assign load = finish && out_free;
	assign res  = res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= '0;
			count_q      <= '0;
			tag_valid_s1 <= 1'b0;
		end else begin
			tag_valid_s1 <= (state_q == ST_WALK) && rd_en;
			case (state_q)
				ST_CLEAR:  addr_q <= addr_q + ONE_SLOT;
				ST_IDLE:   addr_q <= SLOT_W'(source_vertex) - TWO_SLOT;
				ST_READ:   addr_q <= slot;
				ST_WALK:   addr_q <= addr_q + step;
				default:   addr_q <= addr_q;
			endcase
			if (state_q == ST_UPDATE) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		tag_fw_s1 <= inc_q ? (u_q < v_q) : (u_q > v_q);
		if (accept) begin
			op_q   <= operation;
			v_q    <= source_vertex;
			lo_q   <= lo_d;
			hi_q   <= hi_d;
			fwd_q  <= source_vertex < target_vertex;
			inc_q  <= operation == OP_INDEG;
			prod_q <= PROD_W'(lo_d - VID_W'(1)) * PROD_W'(lo_d);
			u_q    <= VID_W'(1);
			cnt_q  <= '0;
		end else if (state_q == ST_WALK) begin
			u_q   <= u_q + VID_W'(1);
			cnt_q <= cnt_d;
		end
		if (finish && !out_free) begin
			res_q <= res_d;
		end
	end

	`DGES_ASSERT_NXT(a_count_hold, clk, arst_n, state_q != ST_UPDATE, $stable(count_q), "edge count moved outside an update")
	`DGES_ASSERT_IMP(a_rd_range, clk, arst_n, rd_en, 32'(rd_addr) < EDGE_SLOTS, "read beyond the edge slots")
	`DGES_ASSERT_IMP(a_no_rw_overlap, clk, arst_n, rd_en, !wr_en, "read and write in one cycle")
	`DGES_ASSERT_NXT(a_hold_on_stall, clk, arst_n, finish && !out_free, state_q == ST_HOLD, "result lost while output stalled")

endmodule

`default_nettype wire
